// File: design/lcs_pkg.sv
// Shared constants and types for the life cell stencil stream.
package lcs_pkg;

  localparam int MAX_COLS = 256;
  localparam int MAX_ROWS = 256;
  localparam int COL_W = $clog2(MAX_COLS);
  localparam int SIZE_W = 9;

  typedef logic [2:0][2:0] window_t;

  typedef struct packed {
    logic is_top;
    logic is_bottom;
    logic is_left;
    logic is_right;
  } bound_t;

endpackage

// File: design/lcs_rule.sv
// Neighbor count with grid border masking and the B3/S23 rule.
module lcs_rule (
  input  lcs_pkg::window_t win,
  input  lcs_pkg::bound_t  bound,
  output logic             next_alive
);

  logic [3:0] cnt;
  logic       use_cell;

  always_comb begin
    cnt = '0;
    use_cell = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        use_cell = !(r == 1 && c == 1);
        if (r == 0 && bound.is_top) use_cell = 1'b0;
        if (r == 2 && bound.is_bottom) use_cell = 1'b0;
        if (c == 0 && bound.is_left) use_cell = 1'b0;
        if (c == 2 && bound.is_right) use_cell = 1'b0;
        if (use_cell) cnt = cnt + {3'b000, win[r][c]};
      end
    end
  end

  always_comb begin
    if (win[1][1]) begin
      next_alive = (cnt == 4'd2) || (cnt == 4'd3);
    end else begin
      next_alive = (cnt == 4'd3);
    end
  end

endmodule

// File: design/life_cell_stencil_stream.sv
// Streaming next-generation life stencil with two line stores and a 3x3 window.
// The input beat that completes a window is registered in stage 1 (s1_*); its result beat
// is loaded into the output register when stage 1 moves, which output backpressure can hold.
// Throughput: one input beat per cycle; only output backpressure stalls the input side.
// Reset: grid sizes return to 200, counters, window and valid flags clear.
// The line stores are not cleared; entries never written only reach masked window cells.
module life_cell_stencil_stream (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [0] cell_alive, [7:1] zero
  input  logic [0:0]  in_tuser,   // [0] flush
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // [0] next_alive, [8:1] out_row, [16:9] out_col, [23:17] zero
  output logic        out_tlast,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic [2:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output logic [31:0] cfg_prdata,
  output logic        cfg_pready
);

  localparam logic REG_ROWS = 1'b0;
  localparam logic REG_COLS = 1'b1;
  localparam int SW = lcs_pkg::SIZE_W;
  localparam int CW = lcs_pkg::COL_W;

  logic [SW-1:0] grid_rows_r, grid_cols_r, rows_eff, cols_eff;
  logic          cfg_wr;

  logic [SW-1:0] irow_cnt_r;
  logic [CW-1:0] icol_cnt_r;
  logic [7:0]    orow_cnt_r, ocol_cnt_r;

  logic          in_acc, x_in, emit, last;
  logic [SW-1:0] icol_inc, ocol_inc, orow_inc;
  lcs_pkg::bound_t bound;

  logic upper_mem [lcs_pkg::MAX_COLS];
  logic middle_mem [lcs_pkg::MAX_COLS];

  logic            s1_v_r, s1_x_r, s1_mid_r, s1_up_raw_r, s1_emit_r, s1_last_r;
  logic            up_byp_r, up_byp_val_r, wr_pend_r;
  logic [CW-1:0]   s1_addr_r;
  logic [7:0]      s1_row_r, s1_col_r;
  lcs_pkg::bound_t s1_bound_r;
  logic            s1_up, s1_move, out_ok;

  lcs_pkg::window_t win_r, win_nxt;
  logic             alive_nxt;

  logic       out_valid_r, res_alive_r, res_last_r;
  logic [7:0] res_row_r, res_col_r;

  assign cfg_pready = 1'b1;
  assign cfg_wr = cfg_psel & cfg_penable & cfg_pwrite & cfg_pready;
  assign cfg_prdata = (cfg_paddr[2] == REG_COLS) ? {{(32-SW){1'b0}}, grid_cols_r}
                                                 : {{(32-SW){1'b0}}, grid_rows_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      grid_rows_r <= SW'(200);
      grid_cols_r <= SW'(200);
    end else if (cfg_wr) begin
      unique case (cfg_paddr[2])
        REG_ROWS: grid_rows_r <= cfg_pwdata[SW-1:0];
        REG_COLS: grid_cols_r <= cfg_pwdata[SW-1:0];
        default: ;
      endcase
    end
  end

  assign rows_eff = (grid_rows_r == '0) ? SW'(1) :
                    (grid_rows_r > SW'(lcs_pkg::MAX_ROWS)) ? SW'(lcs_pkg::MAX_ROWS) : grid_rows_r;
  assign cols_eff = (grid_cols_r == '0) ? SW'(1) :
                    (grid_cols_r > SW'(lcs_pkg::MAX_COLS)) ? SW'(lcs_pkg::MAX_COLS) : grid_cols_r;

  assign out_ok    = !out_valid_r || out_tready;
  assign s1_move   = s1_v_r && (!s1_emit_r || out_ok);
  assign in_tready = !s1_v_r || s1_move;
  assign in_acc    = in_tvalid && in_tready;
  assign x_in      = in_tuser[0] ? 1'b0 : in_tdata[0];

  assign icol_inc = SW'(icol_cnt_r) + SW'(1);
  assign ocol_inc = SW'(ocol_cnt_r) + SW'(1);
  assign orow_inc = SW'(orow_cnt_r) + SW'(1);
  assign emit = (irow_cnt_r >= SW'(2)) || ((irow_cnt_r == SW'(1)) && (icol_cnt_r != '0));
  assign bound.is_top    = (orow_cnt_r == '0);
  assign bound.is_bottom = (orow_inc >= rows_eff);
  assign bound.is_left   = (ocol_cnt_r == '0);
  assign bound.is_right  = (ocol_inc >= cols_eff);
  assign last = bound.is_bottom && bound.is_right;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      irow_cnt_r <= '0;
      icol_cnt_r <= '0;
      orow_cnt_r <= '0;
      ocol_cnt_r <= '0;
    end else if (in_acc) begin
      if (emit && last) begin
        irow_cnt_r <= '0;
        icol_cnt_r <= '0;
        orow_cnt_r <= '0;
        ocol_cnt_r <= '0;
      end else begin
        if (icol_inc >= cols_eff) begin
          icol_cnt_r <= '0;
          irow_cnt_r <= irow_cnt_r + SW'(1);
        end else begin
          icol_cnt_r <= icol_cnt_r + CW'(1);
        end
        if (emit) begin
          if (bound.is_right) begin
            ocol_cnt_r <= '0;
            orow_cnt_r <= orow_cnt_r + 8'd1;
          end else begin
            ocol_cnt_r <= ocol_cnt_r + 8'd1;
          end
        end
      end
    end
  end

  // The upper store takes the old middle value through a delayed write (wr_pend_r), so a read
  // of the same column while that write is pending takes that value from the bypass.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mid_r    <= middle_mem[icol_cnt_r];
      s1_up_raw_r <= upper_mem[icol_cnt_r];
      middle_mem[icol_cnt_r] <= x_in;
      up_byp_r     <= wr_pend_r && (s1_addr_r == icol_cnt_r);
      up_byp_val_r <= s1_mid_r;
      s1_addr_r  <= icol_cnt_r;
      s1_x_r     <= x_in;
      s1_emit_r  <= emit;
      s1_last_r  <= last;
      s1_bound_r <= bound;
      s1_row_r   <= orow_cnt_r;
      s1_col_r   <= ocol_cnt_r;
    end
    if (wr_pend_r) begin
      upper_mem[s1_addr_r] <= s1_mid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r    <= 1'b0;
      wr_pend_r <= 1'b0;
    end else begin
      wr_pend_r <= in_acc;
      if (in_acc) begin
        s1_v_r <= 1'b1;
      end else if (s1_move) begin
        s1_v_r <= 1'b0;
      end
    end
  end

  assign s1_up = up_byp_r ? up_byp_val_r : s1_up_raw_r;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_nxt[r][0] = win_r[r][1];
      win_nxt[r][1] = win_r[r][2];
    end
    win_nxt[0][2] = s1_up;
    win_nxt[1][2] = s1_mid_r;
    win_nxt[2][2] = s1_x_r;
  end

  lcs_rule u_rule (
    .win        (win_nxt),
    .bound      (s1_bound_r),
    .next_alive (alive_nxt)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_move) begin
        win_r <= win_nxt;
      end
      if (s1_move && s1_emit_r) begin
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move && s1_emit_r) begin
      res_alive_r <= alive_nxt;
      res_row_r   <= s1_row_r;
      res_col_r   <= s1_col_r;
      res_last_r  <= s1_last_r;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {7'b0, res_col_r, res_row_r, res_alive_r};
  assign out_tlast  = res_last_r;

`ifndef NO_ASSERTIONS
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    !in_tready |-> (s1_v_r && s1_emit_r && out_valid_r && !out_tready))
    else $error("input stalled without a blocked result");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && s1_emit_r) |=> out_valid_r)
    else $error("result beat lost on its way to the output register");

  a_frame_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && emit && last) |=>
      (irow_cnt_r == '0 && icol_cnt_r == '0 && orow_cnt_r == '0 && ocol_cnt_r == '0))
    else $error("counters not cleared after the last cell of a generation");
`endif

endmodule
